[rtl/core/smt_pkg.sv]
`default_nettype none

package smt_pkg;

   localparam int SMT_DEPTH    = 32;
   localparam int SMT_KEY_BITS = 16;

   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 6;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   localparam logic CSR_IDX_CAPACITY = 1'b0;

   localparam logic [FUNC_W-1:0] FUNC_INSERT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COUNT_EQ  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_COUNT_LT  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_DEL_UPD,
      ST_SCAN_RD,
      ST_SCAN_ACC,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_PTR_M1,
      RD_PTR,
      RD_HELD_M2
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       ptr_held;
      logic       ptr_zero;
      logic       ptr_dec;
      logic       ptr_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_shift;
      logic       wr_key;
      logic       held_inc;
      logic       held_dec;
      logic       max_from_rd;
      logic       match_acc;
      logic       set_full;
      logic       set_empty;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              held_zero;
      logic              held_one;
      logic              rd_gt_key;
      logic              ptr_one;
      logic              scan_last;
      logic              rsp_free;
   } stat_type;

endpackage

`default_nettype wire

[rtl/core/smt_ram.sv]
`default_nettype none

module smt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/core/smt_ctrl.sv]
`default_nettype none

module smt_ctrl
   import smt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (stat.func)
               FUNC_INSERT: begin
                  if (stat.full)           state_in = ST_FINISH;
                  else if (stat.held_zero) state_in = ST_INS_PUT;
                  else                     state_in = ST_INS_RD;
               end
               FUNC_DELETE: begin
                  if (stat.held_zero || stat.held_one) state_in = ST_FINISH;
                  else                                 state_in = ST_DEL_UPD;
               end
               default: begin
                  if (stat.held_zero) state_in = ST_FINISH;
                  else                state_in = ST_SCAN_RD;
               end
            endcase
         end
         ST_INS_RD:  state_in = ST_INS_CMP;
         ST_INS_CMP: begin
            if (stat.rd_gt_key && !stat.ptr_one) state_in = ST_INS_RD;
            else                                 state_in = ST_INS_PUT;
         end
         ST_INS_PUT:  state_in = ST_FINISH;
         ST_DEL_UPD:  state_in = ST_FINISH;
         ST_SCAN_RD:  state_in = ST_SCAN_ACC;
         ST_SCAN_ACC: begin
            if (stat.scan_last) state_in = ST_FINISH;
            else                state_in = ST_SCAN_RD;
         end
         ST_FINISH: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_PTR;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_DISPATCH: begin
            case (stat.func)
               FUNC_INSERT: begin
                  if (stat.full)           cmd.set_full = 1'b1;
                  else if (stat.held_zero) cmd.ptr_zero = 1'b1;
                  else                     cmd.ptr_held = 1'b1;
               end
               FUNC_DELETE: begin
                  if (stat.held_zero) begin
                     cmd.set_empty = 1'b1;
                  end else if (stat.held_one) begin
                     cmd.held_dec = 1'b1;
                  end else begin
                     // fetch the key that becomes the new largest
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_HELD_M2;
                  end
               end
               default: begin
                  cmd.ptr_zero = 1'b1;
               end
            endcase
         end
         ST_INS_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR_M1;
         end
         ST_INS_CMP: begin
            // move the larger neighbour up one place
            if (stat.rd_gt_key) begin
               cmd.wr_shift = 1'b1;
               cmd.ptr_dec  = 1'b1;
            end
         end
         ST_INS_PUT: begin
            cmd.wr_key   = 1'b1;
            cmd.held_inc = 1'b1;
         end
         ST_DEL_UPD: begin
            cmd.max_from_rd = 1'b1;
            cmd.held_dec    = 1'b1;
         end
         ST_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR;
         end
         ST_SCAN_ACC: begin
            cmd.match_acc = 1'b1;
            cmd.ptr_inc   = 1'b1;
         end
         ST_FINISH: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/smt_dpath.sv]
`default_nettype none

module smt_dpath
   import smt_pkg::*;
#(
   parameter int  DEPTH    = SMT_DEPTH,
   parameter int  KEY_BITS = SMT_KEY_BITS,
   localparam int CNT_W    = $clog2(DEPTH + 1),
   localparam int AW       = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [KEY_BITS-1:0] req_key,
   input  wire logic [CAP_W-1:0]    capacity,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [CNT_W-1:0]         rsp_match,
   output logic [KEY_BITS-1:0]      rsp_smallest,
   output logic [KEY_BITS-1:0]      rsp_largest,
   output logic [CNT_W-1:0]         rsp_entries
);

   localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [FUNC_W-1:0]   func_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]    match_ff, match_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [KEY_BITS-1:0] min_ff, min_in;
   logic [KEY_BITS-1:0] max_ff, max_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]    rsp_match_ff;
   logic [KEY_BITS-1:0] rsp_smallest_ff;
   logic [KEY_BITS-1:0] rsp_largest_ff;
   logic [CNT_W-1:0]    rsp_entries_ff;

   logic [KEY_BITS-1:0] rd_data;
   logic [CNT_W-1:0]    ptr_m1, held_m2, ptr_p1;
   logic [CNT_W-1:0]    rd_ptr;
   logic [LIM_W-1:0]    limit;
   logic                hit;

   assign ptr_m1  = ptr_ff - CNT_W'(1);
   assign ptr_p1  = ptr_ff + CNT_W'(1);
   assign held_m2 = held_ff - CNT_W'(2);

   always_comb begin
      case (cmd.rd_sel)
         RD_PTR_M1:  rd_ptr = ptr_m1;
         RD_HELD_M2: rd_ptr = held_m2;
         default:    rd_ptr = ptr_ff;
      endcase
   end

   smt_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH)
   ) u_keys (
      .clock (clock),
      .wr_en (cmd.wr_shift | cmd.wr_key),
      .waddr (ptr_ff[AW-1:0]),
      .wdata (cmd.wr_shift ? rd_data : key_ff),
      .rd_en (cmd.rd_en),
      .raddr (rd_ptr[AW-1:0]),
      .rdata (rd_data)
   );

   // clamp the configured capacity to the storage depth
   always_comb begin
      if (LIM_W'(capacity) < LIM_W'(DEPTH)) limit = LIM_W'(capacity);
      else                                   limit = LIM_W'(DEPTH);
   end

   assign hit = (func_ff == FUNC_COUNT_EQ) ? (rd_data == key_ff) : (rd_data < key_ff);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_held)      ptr_in = held_ff;
      else if (cmd.ptr_zero) ptr_in = '0;
      else if (cmd.ptr_dec)  ptr_in = ptr_m1;
      else if (cmd.ptr_inc)  ptr_in = ptr_p1;

      held_in = held_ff;
      if (cmd.held_inc)      held_in = held_ff + CNT_W'(1);
      else if (cmd.held_dec) held_in = held_ff - CNT_W'(1);

      match_in = match_ff;
      if (cmd.load_req)                     match_in = '0;
      else if (cmd.match_acc && hit)        match_in = match_ff + CNT_W'(1);

      status_in = status_ff;
      if (cmd.load_req)       status_in = STATUS_OK;
      else if (cmd.set_full)  status_in = STATUS_FULL;
      else if (cmd.set_empty) status_in = STATUS_EMPTY;

      min_in = min_ff;
      max_in = max_ff;
      if (cmd.held_inc) begin
         if (held_ff == '0) begin
            min_in = key_ff;
            max_in = key_ff;
         end else begin
            if (key_ff < min_ff)   min_in = key_ff;
            if (key_ff >= max_ff)  max_in = key_ff;
         end
      end else if (cmd.max_from_rd) begin
         max_in = rd_data;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)      rsp_valid_in = 1'b1;
      else if (rsp_tready)   rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         key_ff  <= req_key;
      end
      ptr_ff    <= ptr_in;
      match_ff  <= match_in;
      status_ff <= status_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      if (cmd.rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_match_ff    <= match_ff;
         rsp_entries_ff  <= held_ff;
         rsp_smallest_ff <= (held_ff == '0) ? '0 : min_ff;
         rsp_largest_ff  <= (held_ff == '0) ? '0 : max_ff;
      end
   end

   assign stat.func      = func_ff;
   assign stat.full      = LIM_W'(held_ff) >= limit;
   assign stat.held_zero = held_ff == '0;
   assign stat.held_one  = held_ff == CNT_W'(1);
   assign stat.rd_gt_key = rd_data > key_ff;
   assign stat.ptr_one   = ptr_ff == CNT_W'(1);
   assign stat.scan_last = ptr_p1 == held_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_match    = rsp_match_ff;
   assign rsp_smallest = rsp_smallest_ff;
   assign rsp_largest  = rsp_largest_ff;
   assign rsp_entries  = rsp_entries_ff;

endmodule

`default_nettype wire

[rtl/core/sorted_multiset_table.sv]
`default_nettype none

// Channel   Direction  Handshake                 Contents
// req_      in         req_tvalid / req_tready   func, key
// rsp_      out        rsp_tvalid / rsp_tready   status, match_count, smallest, largest,
//                                                entry_count
// csr_      in         APB write/read            capacity at byte address 0
//
// One request at a time. Insert moves each stored key larger than the new one up
// one place, reading it and then writing it back; delete reads at most the key that
// becomes the new largest; both counts read every key held; a refused request
// touches no key. The key RAM has a single read port, whose read data is registered.
// The final state holds while an earlier response still waits on rsp_tready, and a
// new request is taken while the previous response waits. Reset is synchronous and
// empties the table; capacity returns to 32.

module sorted_multiset_table
   import smt_pkg::*;
#(
   parameter int  DEPTH    = SMT_DEPTH,
   parameter int  KEY_BITS = SMT_KEY_BITS,
   localparam int CNT_W    = $clog2(DEPTH + 1),
   localparam int REQ_W    = ((FUNC_W + KEY_BITS + 7) / 8) * 8,
   localparam int RSP_USED = STATUS_W + CNT_W + 2 * KEY_BITS + CNT_W,
   localparam int RSP_W    = ((RSP_USED + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // func, key
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,   // status, match_count, smallest, largest,
                                               // entry_count
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]       csr_prdata,
   output logic                   csr_pready
);

   logic [CAP_W-1:0]    capacity_ff;
   logic [CAP_W-1:0]    capacity_in;
   cmd_type             cmd;
   stat_type            stat;
   logic [STATUS_W-1:0] rsp_status;
   logic [CNT_W-1:0]    rsp_match;
   logic [KEY_BITS-1:0] rsp_smallest;
   logic [KEY_BITS-1:0] rsp_largest;
   logic [CNT_W-1:0]    rsp_entries;
   logic                csr_sel_cap;

   assign csr_pready  = 1'b1;
   assign csr_sel_cap = csr_paddr[2] == CSR_IDX_CAPACITY;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_cap) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign csr_prdata = csr_sel_cap ? CSR_W'(capacity_ff) : '0;

   smt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   smt_dpath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_func     (req_tdata[FUNC_W-1:0]),
      .req_key      (req_tdata[FUNC_W +: KEY_BITS]),
      .capacity     (capacity_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_match    (rsp_match),
      .rsp_smallest (rsp_smallest),
      .rsp_largest  (rsp_largest),
      .rsp_entries  (rsp_entries)
   );

   assign rsp_tdata = RSP_W'({rsp_entries, rsp_largest, rsp_smallest, rsp_match, rsp_status});

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STATUS_EMPTY |-> rsp_entries == '0)
      else $error("empty status with keys still held");

   a_empty_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_entries == '0 |-> rsp_smallest == '0 && rsp_largest == '0)
      else $error("empty table reports non-zero bounds");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_entries != '0 |-> rsp_smallest <= rsp_largest)
      else $error("smallest key above largest key");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_entries <= CNT_W'(DEPTH) && rsp_match <= rsp_entries)
      else $error("count beyond table contents");

endmodule

`default_nettype wire

[dv/sorted_multiset_table_checker.sv]
`default_nettype none

module sorted_multiset_table_checker
   import smt_pkg::*;
#(
   localparam int CNT_W = $clog2(SMT_DEPTH + 1),
   localparam int REQ_W = ((FUNC_W + SMT_KEY_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((STATUS_W + 2 * CNT_W + 2 * SMT_KEY_BITS + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // func, key
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [RSP_W-1:0]  rsp_tdata,   // status, match_count, smallest, largest,
                                               // entry_count
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_W-1:0]  csr_pwdata,
   input  wire logic [CSR_W-1:0]  csr_prdata,
   input  wire logic              csr_pready,
   output int                     error_count,
   output int                     outstanding
);

   localparam logic [CSR_AW-1:0] CAP_ADDR = CSR_AW'(int'(CSR_IDX_CAPACITY) * 4);

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [CNT_W-1:0]        match_count;
      logic [SMT_KEY_BITS-1:0] smallest;
      logic [SMT_KEY_BITS-1:0] largest;
      logic [CNT_W-1:0]        entry_count;
   } table_result_type;

   logic [SMT_KEY_BITS-1:0] shadow_keys [SMT_DEPTH];
   int unsigned             shadow_held;
   logic [CAP_W-1:0]        shadow_capacity;
   table_result_type        pending_results [$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // Apply one request to the shadow table and queue the result it should give.
   task automatic update_sorted_keys(input logic [FUNC_W-1:0] func,
                                     input logic [SMT_KEY_BITS-1:0] key);
      table_result_type res;
      int unsigned      limit;
      int unsigned      pos;
      begin
         res = '0;
         limit = (int'(shadow_capacity) < SMT_DEPTH) ? int'(shadow_capacity) : SMT_DEPTH;
         case (func)
            FUNC_INSERT: begin
               if (shadow_held >= limit) begin
                  res.status = STATUS_FULL;
               end else begin
                  // equal keys stay ahead of the new one
                  pos = shadow_held;
                  while (pos > 0 && shadow_keys[pos-1] > key) begin
                     shadow_keys[pos] = shadow_keys[pos-1];
                     pos--;
                  end
                  shadow_keys[pos] = key;
                  shadow_held++;
               end
            end
            FUNC_DELETE: begin
               if (shadow_held == 0) res.status = STATUS_EMPTY;
               else shadow_held--;
            end
            FUNC_COUNT_EQ: begin
               for (int unsigned i = 0; i < shadow_held; i++)
                  if (shadow_keys[i] == key) res.match_count++;
            end
            default: begin
               for (int unsigned i = 0; i < shadow_held; i++)
                  if (shadow_keys[i] < key) res.match_count++;
            end
         endcase
         if (shadow_held != 0) begin
            res.smallest = shadow_keys[0];
            res.largest  = shadow_keys[shadow_held-1];
         end
         res.entry_count = CNT_W'(shadow_held);
         pending_results.push_back(res);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      begin
         if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      table_result_type exp_res;
      table_result_type act_res;
      if (reset) begin
         shadow_held = 0;
         shadow_capacity = CAP_RESET;
         pending_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CAP_ADDR) begin
            if (csr_pwrite) shadow_capacity = csr_pwdata[CAP_W-1:0];
            else compare_field("capacity", CSR_W'(shadow_capacity), csr_prdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            act_res.status      = rsp_tdata[STATUS_W-1:0];
            act_res.match_count = rsp_tdata[STATUS_W +: CNT_W];
            act_res.smallest    = rsp_tdata[STATUS_W + CNT_W +: SMT_KEY_BITS];
            act_res.largest     = rsp_tdata[STATUS_W + CNT_W + SMT_KEY_BITS +: SMT_KEY_BITS];
            act_res.entry_count = rsp_tdata[STATUS_W + CNT_W + 2 * SMT_KEY_BITS +: CNT_W];
            if (pending_results.size() == 0) begin
               $error("response with no request waiting: %h", rsp_tdata);
               error_count++;
            end else begin
               exp_res = pending_results.pop_front();
               compare_field("status", 32'(exp_res.status), 32'(act_res.status));
               compare_field("match_count", 32'(exp_res.match_count),
                             32'(act_res.match_count));
               compare_field("smallest", 32'(exp_res.smallest), 32'(act_res.smallest));
               compare_field("largest", 32'(exp_res.largest), 32'(act_res.largest));
               compare_field("entry_count", 32'(exp_res.entry_count),
                             32'(act_res.entry_count));
            end
         end
         if (req_tvalid && req_tready)
            update_sorted_keys(req_tdata[FUNC_W-1:0], req_tdata[FUNC_W +: SMT_KEY_BITS]);
      end
      outstanding = pending_results.size();
   end

endmodule

`default_nettype wire

[dv/sorted_multiset_table_tb.sv]
`default_nettype none

module sorted_multiset_table_tb;
   import smt_pkg::*;

   localparam int CNT_W = $clog2(SMT_DEPTH + 1);
   localparam int REQ_W = ((FUNC_W + SMT_KEY_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((STATUS_W + 2 * CNT_W + 2 * SMT_KEY_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_AW-1:0] CAP_ADDR   = CSR_AW'(int'(CSR_IDX_CAPACITY) * 4);
   localparam logic [CSR_AW-1:0] SPARE_ADDR = CSR_AW'((int'(CSR_IDX_CAPACITY) + 1) * 4);

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // func, key
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // status, match_count, smallest, largest, entry_count
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_W-1:0]  csr_pwdata;
   logic [CSR_W-1:0]  csr_prdata;
   logic              csr_pready;

   int                      error_count;
   int                      outstanding;
   int                      cycle_count = 0;
   int                      burst_left;
   logic [SMT_KEY_BITS-1:0] recent_keys [8];
   int                      recent_wr = 0;

   sorted_multiset_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sorted_multiset_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: alternate between always ready, coin-flip and mostly stalled.
   initial begin
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(1));
               default: rsp_tready <= ($urandom_range(7) == 0);
            endcase
         end
      end
   end

   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [SMT_KEY_BITS-1:0] key);
      begin
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tdata  <= REQ_W'({key, func});
         do @(posedge clock); while (!req_tready);
         if (func == FUNC_INSERT) begin
            recent_keys[recent_wr] = key;
            recent_wr = (recent_wr + 1) % 8;
         end
      end
   endtask

   task automatic hold_idle(input int cycles);
      begin
         repeat (cycles) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
   endtask

   task automatic csr_access(input logic write, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_W-1:0] data);
      begin
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= write;
         csr_paddr   <= addr;
         csr_pwdata  <= data;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   // Drain the table's response queue, then change the capacity.
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      logic [CSR_W-1:0] data;
      begin
         hold_idle(1);
         do @(negedge clock); while (outstanding != 0);
         repeat (4) @(negedge clock);
         data = $urandom();
         data[CAP_W-1:0] = cap;
         csr_access(1'b1, CAP_ADDR, data);
         if ($urandom_range(1)) csr_access(1'b1, SPARE_ADDR, $urandom());
         csr_access(1'b0, CAP_ADDR, '0);
      end
   endtask

   function automatic logic [SMT_KEY_BITS-1:0] pick_key();
      int r;
      begin
         r = $urandom_range(99);
         if (r < 15) return recent_keys[$urandom_range(7)];
         if (r < 25) begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return SMT_KEY_BITS'(1);
               2:       return {SMT_KEY_BITS{1'b1}} - SMT_KEY_BITS'(1);
               default: return '1;
            endcase
         end
         if (r < 50) return SMT_KEY_BITS'($urandom_range(15));
         return SMT_KEY_BITS'($urandom());
      end
   endfunction

   task automatic run_items(input int count, input int insert_pct);
      logic [FUNC_W-1:0] func;
      begin
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < insert_pct) func = FUNC_INSERT;
            else func = FUNC_W'($urandom_range(1, 3));
            send_request(func, pick_key());
            burst_left--;
            if (burst_left <= 0) begin
               hold_idle($urandom_range(0, 8));
               burst_left = ($urandom_range(4) == 0) ? 40 : $urandom_range(1, 16);
            end
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      burst_left  = 8;
      for (int i = 0; i < 8; i++) recent_keys[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: counts read zero, delete is refused
      send_request(FUNC_COUNT_EQ, '0);
      send_request(FUNC_COUNT_LT, '1);
      send_request(FUNC_DELETE, 16'h1234);
      // extremes and equal keys
      send_request(FUNC_INSERT, 16'd100);
      send_request(FUNC_INSERT, 16'd100);
      send_request(FUNC_INSERT, '0);
      send_request(FUNC_INSERT, '1);
      send_request(FUNC_INSERT, 16'd100);
      send_request(FUNC_INSERT, 16'h8000);
      send_request(FUNC_INSERT, 16'h7FFF);
      send_request(FUNC_COUNT_EQ, 16'd100);
      send_request(FUNC_COUNT_LT, 16'd100);
      send_request(FUNC_COUNT_LT, '0);
      send_request(FUNC_COUNT_EQ, '1);
      send_request(FUNC_COUNT_LT, '1);
      send_request(FUNC_COUNT_EQ, 16'd5);
      send_request(FUNC_COUNT_LT, 16'hAAAA);
      send_request(FUNC_COUNT_EQ, 16'h5555);
      repeat (7) send_request(FUNC_DELETE, '1);
      send_request(FUNC_DELETE, '0);

      // table filled to the top, then capacity dropped below the count
      run_items(90, 75);
      run_items(40, 90);
      set_capacity(6'd6);
      run_items(40, 35);
      set_capacity(6'd0);
      run_items(25, 60);
      set_capacity(6'd1);
      run_items(30, 55);
      set_capacity(6'd63);
      run_items(60, 70);
      set_capacity(6'd33);
      run_items(40, 60);
      set_capacity(6'd2);
      run_items(30, 50);
      set_capacity(6'd32);
      run_items(60, 25);
      set_capacity(CAP_W'($urandom_range(63)));
      run_items(50, 55);
      set_capacity(6'd32);
      run_items(35, 50);

      hold_idle(1);
      do @(negedge clock); while (outstanding != 0);
      repeat (20) @(negedge clock);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
